// File: rtl/mtug_pkg.sv
// Shared types and constants for the MT19937 uniform generator.
// Holds the channel payloads, the controller/datapath command and status
// bundles, the request kind codes and the generator constants. No dependencies.
`default_nettype none

package mtug_pkg;

  localparam int unsigned STATE_WORDS  = 624;
  localparam int unsigned TWIST_OFFSET = 397;
  localparam int unsigned ADDR_W       = $clog2(STATE_WORDS);

  localparam logic [ADDR_W-1:0] WORDS_FULL   = ADDR_W'(STATE_WORDS);
  localparam logic [ADDR_W-1:0] LAST_WORD    = ADDR_W'(STATE_WORDS - 1);
  localparam logic [ADDR_W-1:0] NEVER_SEEDED = ADDR_W'(STATE_WORDS + 1);
  localparam logic [ADDR_W-1:0] FAR_OFFSET   = ADDR_W'(TWIST_OFFSET);

  localparam logic [31:0] TWIST_MATRIX = 32'h9908_b0df;
  localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;
  localparam logic [31:0] LCG_MULT     = 32'd69069;
  localparam logic [31:0] DEFAULT_SEED = 32'd4357;

  // Request kind codes. Code 3 is ignored.
  localparam logic [1:0] KIND_DRAW = 2'd0;
  localparam logic [1:0] KIND_SEED = 2'd1;
  localparam logic [1:0] KIND_LOAD = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] word_value;
    logic [9:0]  word_index;
  } mtug_req_t;

  typedef struct packed {
    logic [31:0] random_word;
  } mtug_rsp_t;

  typedef struct packed {
    logic load_wr;    // write at most one word from the request, mark state for a twist
    logic seed_init;  // load the LCG and restart the word counter
    logic seed_dflt;  // seed from the default value instead of the request
    logic seed_step;  // one LCG step, a word written every second step
    logic tw_prime;   // read word 0 ahead of the twist
    logic tw_step;    // issue the reads of one twist step
    logic rd_pos;     // read the word at the read position
    logic out_load;   // temper the read word into the result register
  } mtug_cmd_t;

  typedef struct packed {
    logic pos_full;   // read position equals the word count
    logic pos_never;  // block was never seeded or loaded
    logic seed_last;  // current seed step writes the last word
    logic tw_last;    // current twist step is the last one
    logic out_free;   // result register can take a word this cycle
  } mtug_status_t;

endpackage

`default_nettype wire

// File: rtl/mtug_stream_if.sv
// Valid/ready channel carrying one payload per beat.
// The payload type is a parameter; no package dependency.
`default_nettype none

interface mtug_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

// File: rtl/mtug_ctrl.sv
// Sequencer for the MT19937 generator: decodes requests and steps the
// datapath through seeding, twisting and word delivery. Uses mtug_pkg.
`default_nettype none

module mtug_ctrl
  import mtug_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         req_valid_i,
  input  wire logic [1:0]   req_kind_i,
  output logic              req_ready_o,
  input  wire mtug_status_t st_i,
  output mtug_cmd_t         cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_TW_PRIME,
    ST_TWIST,
    ST_RD,
    ST_OUT
  } state_e;

  state_e state_q, state_d;
  logic   draw_pend_q, draw_pend_d;

  assign req_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    draw_pend_d = draw_pend_q;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          unique case (req_kind_i)
            KIND_SEED: begin
              cmd_o.seed_init = 1'b1;
              state_d         = ST_SEED;
            end
            KIND_LOAD: begin
              cmd_o.load_wr = 1'b1;
            end
            KIND_DRAW: begin
              if (st_i.pos_never) begin
                // Never seeded: seed with the default value, then twist.
                cmd_o.seed_init = 1'b1;
                cmd_o.seed_dflt = 1'b1;
                draw_pend_d     = 1'b1;
                state_d         = ST_SEED;
              end else if (st_i.pos_full) begin
                cmd_o.tw_prime = 1'b1;
                state_d        = ST_TWIST;
              end else begin
                cmd_o.rd_pos = 1'b1;
                state_d      = ST_OUT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SEED: begin
        cmd_o.seed_step = 1'b1;
        if (st_i.seed_last) begin
          draw_pend_d = 1'b0;
          state_d     = draw_pend_q ? ST_TW_PRIME : ST_IDLE;
        end
      end
      ST_TW_PRIME: begin
        cmd_o.tw_prime = 1'b1;
        state_d        = ST_TWIST;
      end
      ST_TWIST: begin
        cmd_o.tw_step = 1'b1;
        if (st_i.tw_last) begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        cmd_o.rd_pos = 1'b1;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      draw_pend_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      draw_pend_q <= draw_pend_d;
    end
  end

  // A pending draw exists only while the default seed runs.
  a_pend_in_seed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    draw_pend_q |-> state_q == ST_SEED)
    else $error("draw pending outside of seeding");

  // The end of a seed returns to idle or goes on to the twist.
  a_seed_exit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEED) && st_i.seed_last
      |=> (state_q == ST_IDLE) || (state_q == ST_TW_PRIME))
    else $error("seed finished into an unexpected state");

  // A finished twist always delivers a word.
  a_twist_exit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TWIST) && st_i.tw_last |=> state_q == ST_RD ##1 state_q == ST_OUT)
    else $error("twist did not lead to a read");

endmodule

`default_nettype wire

// File: rtl/mtug_dp.sv
// Datapath for the MT19937 generator: the state word memory, the seeding
// LCG, the twist pipeline, tempering and the result register. Uses mtug_pkg.
`default_nettype none

module mtug_dp
  import mtug_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire mtug_req_t req_i,
  input  wire mtug_cmd_t cmd_i,
  output mtug_status_t   st_o,
  output logic           rsp_valid_o,
  input  wire logic      rsp_ready_i,
  output mtug_rsp_t      rsp_o
);

  logic [31:0]       words_q [STATE_WORDS];
  logic [ADDR_W-1:0] pos_q;
  logic [ADDR_W-1:0] idx_q;
  logic              phase_q;
  logic [31:0]       lcg_q;
  logic [15:0]       hi_q;
  logic [31:0]       rda_q, rdb_q;
  logic [31:0]       cur_q;
  logic              wr_pend_q;
  logic [ADDR_W-1:0] wr_idx_q;
  logic              rsp_valid_q;
  logic [31:0]       rsp_word_q;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [31:0]       wdata;
  logic              rda_en, rdb_en;
  logic [ADDR_W-1:0] rda_addr, rdb_addr;
  logic [ADDR_W-1:0] nxt_addr, far_sum, far_addr;
  logic [31:0]       mix_y, twist_word;
  logic [31:0]       lcg_next;
  logic              load_hit;

  function automatic logic [31:0] temper(input logic [31:0] y_in);
    logic [31:0] y;
    y = y_in;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // Twist step addresses: the neighbor word and the word TWIST_OFFSET ahead.
  assign nxt_addr = (idx_q == LAST_WORD) ? '0 : idx_q + ADDR_W'(1);
  assign far_sum  = idx_q + FAR_OFFSET;
  assign far_addr = (far_sum >= WORDS_FULL) ? far_sum - WORDS_FULL : far_sum;

  // cur_q holds the old word k, rda_q the word k+1 and rdb_q the far word.
  assign mix_y      = {cur_q[31], rda_q[30:0]};
  assign twist_word = rdb_q ^ (mix_y >> 1) ^ (mix_y[0] ? TWIST_MATRIX : 32'd0);

  assign lcg_next = 32'(lcg_q * LCG_MULT) + 32'd1;
  assign load_hit = (req_i.word_index < WORDS_FULL);

  always_comb begin
    we    = 1'b0;
    waddr = wr_idx_q;
    wdata = twist_word;
    priority if (cmd_i.load_wr) begin
      we    = load_hit;
      waddr = req_i.word_index;
      wdata = req_i.word_value;
    end else if (cmd_i.seed_step && phase_q) begin
      we    = 1'b1;
      waddr = idx_q;
      wdata = {hi_q, lcg_q[31:16]};
    end else if (wr_pend_q) begin
      we = 1'b1;
    end
  end

  always_comb begin
    rda_en   = cmd_i.rd_pos | cmd_i.tw_prime | cmd_i.tw_step;
    rdb_en   = cmd_i.tw_step;
    rdb_addr = far_addr;
    priority if (cmd_i.rd_pos) begin
      rda_addr = pos_q;
    end else if (cmd_i.tw_prime) begin
      rda_addr = '0;
    end else begin
      rda_addr = nxt_addr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      words_q[waddr] <= wdata;
    end
    if (rda_en) begin
      rda_q <= words_q[rda_addr];
    end
    if (rdb_en) begin
      rdb_q <= words_q[rdb_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.seed_init) begin
      lcg_q <= cmd_i.seed_dflt ? DEFAULT_SEED : req_i.word_value;
    end else if (cmd_i.seed_step) begin
      lcg_q <= lcg_next;
    end
    if (cmd_i.seed_step && !phase_q) begin
      hi_q <= lcg_q[31:16];
    end
    if (cmd_i.tw_step) begin
      cur_q    <= rda_q;
      wr_idx_q <= idx_q;
    end
    if (cmd_i.out_load) begin
      rsp_word_q <= temper(rda_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= NEVER_SEEDED;
      idx_q       <= '0;
      phase_q     <= 1'b0;
      wr_pend_q   <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      wr_pend_q <= cmd_i.tw_step;

      if (cmd_i.seed_init || cmd_i.tw_prime) begin
        idx_q <= '0;
      end else if ((cmd_i.seed_step && phase_q) || cmd_i.tw_step) begin
        idx_q <= idx_q + ADDR_W'(1);
      end

      if (cmd_i.seed_init) begin
        phase_q <= 1'b0;
      end else if (cmd_i.seed_step) begin
        phase_q <= !phase_q;
      end

      if (cmd_i.load_wr || (cmd_i.seed_step && st_o.seed_last)) begin
        pos_q <= WORDS_FULL;
      end else if (cmd_i.tw_step && st_o.tw_last) begin
        pos_q <= '0;
      end else if (cmd_i.out_load) begin
        pos_q <= pos_q + ADDR_W'(1);
      end

      if (cmd_i.out_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  assign st_o.pos_full  = (pos_q == WORDS_FULL);
  assign st_o.pos_never = (pos_q > WORDS_FULL);
  assign st_o.seed_last = phase_q && (idx_q == LAST_WORD);
  assign st_o.tw_last   = (idx_q == LAST_WORD);
  assign st_o.out_free  = !rsp_valid_q || rsp_ready_i;

  assign rsp_valid_o       = rsp_valid_q;
  assign rsp_o.random_word = rsp_word_q;

  // The twist only runs on a state that is fully used up.
  a_twist_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.tw_step |-> pos_q == WORDS_FULL)
    else $error("twist step with read position not at the end");

  // A delivered word always comes from inside the state.
  a_out_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> pos_q < WORDS_FULL)
    else $error("result loaded from a position past the state");

  // A twist write never lands on a word read in the same cycle.
  a_twist_hazard : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_pend_q && cmd_i.tw_step |-> (wr_idx_q != rda_addr) && (wr_idx_q != rdb_addr))
    else $error("twist write collides with a twist read");

endmodule

`default_nettype wire

// File: rtl/mt19937_uniform_generator_core.sv
// Top level of the MT19937 uniform word generator.
// Depends on mtug_pkg, mtug_stream_if, mtug_ctrl and mtug_dp.
//
//   Channel  Dir  Payload                            Beat meaning
//   req_i    in   kind, word_value, word_index       one draw, seed or load request
//   rsp_o    out  random_word                        one tempered word per draw
//
// A load writes at most one word, a seed runs two LCG steps per state word, and a draw
// does the memory read, then tempering into the result register. At the end of the
// state a draw runs a priming read, 624 twist steps, the read and tempering; an
// unseeded draw runs the default seed before that. Reset idles the
// sequencer and marks the block never seeded; the state memory is not cleared.
// A draw waits for a held result to leave, and no request is taken meanwhile.
`default_nettype none

module mt19937_uniform_generator_core
  import mtug_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mtug_stream_if.sink   req_i,
  mtug_stream_if.source rsp_o
);

  // The controller sees of the request only its handshake and kind; the
  // datapath holds every word of state and the result register.
  mtug_cmd_t    cmd;
  mtug_status_t st;
  mtug_req_t    req_payload;
  mtug_rsp_t    rsp_payload;

  assign req_payload   = req_i.payload;
  assign rsp_o.payload = rsp_payload;

  mtug_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_kind_i  (req_payload.kind),
    .req_ready_o (req_i.ready),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  mtug_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_payload),
    .cmd_i       (cmd),
    .st_o        (st),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .rsp_o       (rsp_payload)
  );

endmodule

`default_nettype wire

// File: tb/mt19937_uniform_generator_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for mt19937_uniform_generator_core.
// Depends on mtug_pkg and mtug_stream_if; draws are checked against an
// in-bench copy of the generator state, seed and load beats produce no words.

module mt19937_uniform_generator_core_tb
  import mtug_pkg::*;
();

  // Kind code 3 has no name in the package; the block must drop it.
  localparam logic [1:0]  KIND_IGNORED = 2'd3;

  localparam logic [31:0] UPPER_BIT  = 32'h8000_0000;
  localparam logic [31:0] LOWER_BITS = 32'h7fff_ffff;
  localparam logic [31:0] HALF_MASK  = 32'hffff_0000;

  // Read position held after reset until the first seed or load.
  localparam int unsigned UNSEEDED_POS = STATE_WORDS + 1;

  localparam int unsigned     RANDOM_BEATS = 1350;
  // Long enough to cover a trailing seed and a twist.
  localparam int unsigned     DRAIN_CYCLES = 2500;
  // Worst case per beat: default seed plus twist plus the longest send gap
  // and response stall, over ~1400 beats, with margin.
  localparam longint unsigned CYCLE_LIMIT  = 64'd10_000_000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] word_value;
    logic [9:0]  word_index;
    logic        yields;      // one tempered word is due for this beat
  } drill_row_t;

  // Directed opening. The first draw follows only a dropped beat after reset so that the
  // default seed path is exercised before any load can leave words unwritten.
  localparam int unsigned DRILL_LEN = 23;
  localparam drill_row_t DIRECTED_ROWS [DRILL_LEN] = '{
    '{KIND_IGNORED, 32'hffff_ffff, 10'd1023, 1'b0},  // dropped before any seed
    '{KIND_DRAW,    32'h0000_0000, 10'd0,    1'b1},  // never seeded: default seed, twist
    '{KIND_DRAW,    32'hffff_ffff, 10'd1023, 1'b1},  // draw ignores its other fields
    '{KIND_SEED,    32'h0000_0000, 10'd0,    1'b0},
    '{KIND_DRAW,    32'h0000_0000, 10'd0,    1'b1},
    '{KIND_DRAW,    32'h0000_0000, 10'd0,    1'b1},
    '{KIND_SEED,    32'hffff_ffff, 10'd1023, 1'b0},
    '{KIND_DRAW,    32'h0000_0000, 10'd0,    1'b1},
    '{KIND_SEED,    32'd4357,      10'd0,    1'b0},  // same stream as the default seed
    '{KIND_DRAW,    32'h0000_0000, 10'd0,    1'b1},
    '{KIND_LOAD,    32'hffff_ffff, 10'd0,    1'b0},  // first word
    '{KIND_LOAD,    32'h0000_0000, 10'd623,  1'b0},  // last word
    '{KIND_LOAD,    32'h1234_5678, 10'd624,  1'b0},  // just out of range, writes nothing
    '{KIND_LOAD,    32'ha5a5_a5a5, 10'd1023, 1'b0},  // far out of range
    '{KIND_DRAW,    32'h0000_0000, 10'd0,    1'b1},
    '{KIND_DRAW,    32'h0000_0000, 10'd0,    1'b1},
    '{KIND_IGNORED, 32'h0000_0000, 10'd0,    1'b0},
    '{KIND_DRAW,    32'h0000_0000, 10'd0,    1'b1},
    '{KIND_SEED,    32'h8000_0000, 10'd0,    1'b0},
    '{KIND_LOAD,    32'h7fff_ffff, 10'd311,  1'b0},
    '{KIND_DRAW,    32'h0000_0000, 10'd0,    1'b1},
    '{KIND_LOAD,    32'h5a5a_5a5a, 10'd700,  1'b0},  // out of range alone still forces a twist
    '{KIND_DRAW,    32'h0000_0000, 10'd0,    1'b1}
  };

  logic clk;
  logic rst_n;

  mtug_stream_if #(.payload_t(mtug_req_t)) req_if ();
  mtug_stream_if #(.payload_t(mtug_rsp_t)) rsp_if ();

  mt19937_uniform_generator_core u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Bench copy of the generator: state words and read position.
  logic [31:0] mt_words [STATE_WORDS];
  int unsigned mt_pos;

  // Tempered words predicted at request acceptance, oldest first.
  logic [31:0] pending_words [$];

  int unsigned     fail_count;
  int unsigned     beats_sent;
  int unsigned     send_quiet;
  int unsigned     recv_quiet;
  longint unsigned cycle_count;
  logic [31:0]     expected_word;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Generator model
  // ---------------------------------------------------------------------

  // Old-style seeding: each word takes the upper halves of two successive
  // 69069 LCG values. Leaves the position at the end, so the next draw twists.
  function automatic void seed_words(input logic [31:0] seed);
    logic [31:0] lcg;
    logic [31:0] w;
    int unsigned i;
    lcg = seed;
    for (i = 0; i < STATE_WORDS; i++) begin
      w   = lcg & HALF_MASK;
      lcg = lcg * LCG_MULT + 32'd1;
      w   = w | ((lcg & HALF_MASK) >> 16);
      lcg = lcg * LCG_MULT + 32'd1;
      mt_words[i] = w;
    end
    mt_pos = STATE_WORDS;
  endfunction

  // Full regeneration in place. Late words read partners that were already
  // rewritten earlier in the same pass, exactly as the sequential form does.
  function automatic void twist_words();
    logic [31:0] y;
    logic [31:0] v;
    int unsigned k;
    for (k = 0; k < STATE_WORDS; k++) begin
      y = (mt_words[k] & UPPER_BIT) | (mt_words[(k + 1) % STATE_WORDS] & LOWER_BITS);
      v = mt_words[(k + TWIST_OFFSET) % STATE_WORDS] ^ (y >> 1);
      if (y[0]) begin
        v = v ^ TWIST_MATRIX;
      end
      mt_words[k] = v;
    end
    mt_pos = 0;
  endfunction

  function automatic logic [31:0] temper_word(input logic [31:0] raw);
    logic [31:0] y;
    y = raw;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // Applies one accepted request to the bench state and reports the word,
  // if any, that the block owes for it.
  function automatic void apply_request(input mtug_req_t req, output logic has_word,
                                        output logic [31:0] word);
    has_word = 1'b0;
    word     = '0;
    case (req.kind)
      KIND_SEED: begin
        seed_words(req.word_value);
      end
      KIND_LOAD: begin
        if (req.word_index < STATE_WORDS) begin
          mt_words[req.word_index] = req.word_value;
        end
        mt_pos = STATE_WORDS;
      end
      KIND_DRAW: begin
        if (mt_pos >= STATE_WORDS) begin
          if (mt_pos > STATE_WORDS) begin
            seed_words(DEFAULT_SEED);
          end
          twist_words();
        end
        word     = temper_word(mt_words[mt_pos]);
        mt_pos   = mt_pos + 1;
        has_word = 1'b1;
      end
      default: begin
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Idle length for either side: mostly none, often short, rarely a
  // long one. Now and then a quiet stretch with no idling at all begins.
  function automatic int unsigned pick_gap(inout int unsigned quiet);
    int unsigned r;
    if (quiet != 0) begin
      quiet = quiet - 1;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      quiet = $urandom_range(20, 120);
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] any_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return UPPER_BIT;
      3:       return LOWER_BITS;
      default: return $urandom;
    endcase
  endfunction

  // Drives one request beat, holding valid across back-to-back beats so it
  // is never dropped and raised in the same step. Called at a rising edge.
  task automatic send_beat(input mtug_req_t req, output logic has_word);
    int unsigned gap;
    logic [31:0] word;
    gap = pick_gap(send_quiet);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= req;
    @(posedge clk);
    while (req_if.ready !== 1'b1) @(posedge clk);
    apply_request(req, has_word, word);
    if (has_word) begin
      pending_words.push_back(word);
    end
  endtask

  // Beat built from its fields; ignored kinds do not count toward the beat total.
  task automatic send_kind(input logic [1:0] kind, input logic [31:0] value,
                           input logic [9:0] index);
    mtug_req_t req;
    logic      has_word;
    req.kind       = kind;
    req.word_value = value;
    req.word_index = index;
    send_beat(req, has_word);
    if (kind != KIND_IGNORED) begin
      beats_sent++;
    end
  endtask

  task automatic maybe_noise();
    if ($urandom_range(0, 19) == 0) begin
      send_kind(KIND_IGNORED, $urandom, 10'($urandom_range(0, 1023)));
    end
  endtask

  // Draw beats carry random junk in their unused fields.
  task automatic draw_run(input int unsigned count);
    int unsigned i;
    for (i = 0; i < count; i++) begin
      maybe_noise();
      send_kind(KIND_DRAW, $urandom, 10'($urandom_range(0, 1023)));
    end
  endtask

  // ---------------------------------------------------------------------
  // Response side: random stalls, checked in acceptance order
  // ---------------------------------------------------------------------

  initial begin : rsp_stall_driver
    int unsigned stall;
    rsp_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      stall = pick_gap(recv_quiet);
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (pending_words.size() == 0) begin
        $display("%0t: random_word with none pending: expected none, actual %h",
                 $time, rsp_if.payload.random_word);
        fail_count++;
      end else begin
        expected_word = pending_words.pop_front();
        if (rsp_if.payload.random_word !== expected_word) begin
          $display("%0t: random_word mismatch: expected %h, actual %h",
                   $time, expected_word, rsp_if.payload.random_word);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("mt19937_uniform_generator_core verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------

  initial begin : stimulus
    mtug_req_t   req;
    logic        has_word;
    int unsigned i;
    int unsigned n;
    int unsigned idx;
    fail_count     = 0;
    beats_sent     = 0;
    send_quiet     = 0;
    recv_quiet     = 0;
    cycle_count    = 0;
    rst_n          = 1'b0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    for (i = 0; i < STATE_WORDS; i++) begin
      mt_words[i] = '0;
    end
    mt_pos = UNSEEDED_POS;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows. Whether a word is due is typed into the table; the
    // word itself comes from the bench model.
    for (i = 0; i < DRILL_LEN; i++) begin
      req.kind       = DIRECTED_ROWS[i].kind;
      req.word_value = DIRECTED_ROWS[i].word_value;
      req.word_index = DIRECTED_ROWS[i].word_index;
      send_beat(req, has_word);
      if (has_word !== DIRECTED_ROWS[i].yields) begin
        $display("%0t: directed row %0d word due: expected %b, actual %b",
                 $time, i, DIRECTED_ROWS[i].yields, has_word);
        fail_count++;
      end
    end

    // Full state load word by word, then enough draws to use up every word
    // and force a twist on exhaustion rather than after a seed or load.
    for (i = 0; i < STATE_WORDS; i++) begin
      maybe_noise();
      send_kind(KIND_LOAD, any_word(), 10'(i));
    end
    draw_run(STATE_WORDS + 8);

    // Mixed sequences: draw bursts, reseeds, scattered loads (some out of
    // range) and stray ignored beats. Every word is defined from here on,
    // so any draw is legal.
    while (beats_sent < RANDOM_BEATS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          draw_run($urandom_range(1, 20));
        end
        4, 5: begin
          send_kind(KIND_SEED, any_word(), 10'($urandom_range(0, 1023)));
          draw_run($urandom_range(1, 12));
        end
        6, 7: begin
          n = $urandom_range(1, 3);
          repeat (n) begin
            if ($urandom_range(0, 3) == 0) begin
              idx = $urandom_range(STATE_WORDS, 1023);
            end else begin
              idx = $urandom_range(0, STATE_WORDS - 1);
            end
            send_kind(KIND_LOAD, any_word(), 10'(idx));
          end
          draw_run($urandom_range(1, 8));
        end
        8: begin
          n = $urandom_range(1, 3);
          repeat (n) send_kind(KIND_IGNORED, $urandom, 10'($urandom_range(0, 1023)));
        end
        default: begin
          send_kind(KIND_SEED, any_word(), 10'($urandom_range(0, 1023)));
          send_kind(KIND_LOAD, any_word(), 10'($urandom_range(0, STATE_WORDS - 1)));
          draw_run(1);
        end
      endcase
    end

    req_if.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("mt19937_uniform_generator_core verification clean");
    end else begin
      $display("mt19937_uniform_generator_core verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/mtug_pkg.sv
rtl/mtug_stream_if.sv
rtl/mtug_ctrl.sv
rtl/mtug_dp.sv
rtl/mt19937_uniform_generator_core.sv
tb/mt19937_uniform_generator_core_tb.sv
